/* rtl/pgalloc_pkg.sv */
// Package: shared types, request and status codes for the page id allocator.
package pgalloc_pkg;

  localparam int MAX_PAGES_DEF  = 65536;
  localparam int FREE_DEPTH_DEF = 64;
  localparam int PAGE_W         = 16;
  localparam int COUNT_W        = 17;

  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_FREE    = 3'd1;
  localparam logic [2:0] REQ_QUERY   = 3'd2;
  localparam logic [2:0] REQ_WRITE   = 3'd3;
  localparam logic [2:0] REQ_COMPACT = 3'd4;
  localparam logic [2:0] REQ_OPEN    = 3'd5;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_INVALID   = 3'd1;
  localparam logic [2:0] STS_FULL      = 3'd2;
  localparam logic [2:0] STS_LIMIT     = 3'd3;
  localparam logic [2:0] STS_NOCOMPACT = 3'd4;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] result_page;
    logic              page_is_free;
    logic [2:0]        status;
  } rsp_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_ROT,
    CELL_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [PAGE_W-1:0] push_page;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_SEARCH,
    ST_FILTER
  } state_t;

endpackage

/* rtl/page_id_allocator_free_stack_top.sv */
// Top level: page id allocator with a LIFO free stack held in a chain of cells.
//
//  port group | dir | handshake           | beat
//  in_        | in  | in_valid/in_stall   | one request (req_t)
//  out_       | out | out_valid/out_stall | one response (rsp_t)
//  cfg_       | in  | cfg_valid/cfg_ready | initial page count
//
// Allocate, free, write, open, unknown requests, out-of-range queries, and queries or
// compacts with an empty stack (or compacts with no pages): response registered in the
// cycle after accept. Other queries walk once around the stack ring before responding.
// Compact otherwise: one search pass around the ring per candidate page tried, from
// count-1 down to 0, then a filter pass once a candidate not on the stack is found.
// Synchronous active-low reset clears count, fill and config; cell data is not reset.
// A new request is taken only in idle with the output register free or draining.
module page_id_allocator_free_stack_top #(
  parameter int MAX_PAGES  = pgalloc_pkg::MAX_PAGES_DEF,
  parameter int FREE_DEPTH = pgalloc_pkg::FREE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pgalloc_pkg::req_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pgalloc_pkg::rsp_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pgalloc_pkg::COUNT_W-1:0]   cfg_data
);

  localparam int FILL_W = $clog2(FREE_DEPTH + 1);
  localparam int LIMIT_I = (MAX_PAGES < 65536) ? MAX_PAGES : 65536;
  localparam logic [pgalloc_pkg::COUNT_W-1:0] PAGE_LIMIT = pgalloc_pkg::COUNT_W'(LIMIT_I);
  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(FREE_DEPTH);
  localparam logic [FILL_W-1:0] ONE_F   = FILL_W'(1);

  pgalloc_pkg::state_t state_r, state_nxt;
  logic [pgalloc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [pgalloc_pkg::COUNT_W-1:0] init_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] k_r, k_nxt;
  logic [FILL_W-1:0] len_r, len_nxt;
  logic [pgalloc_pkg::PAGE_W-1:0] key_r, key_nxt;
  logic hit_r, hit_nxt;
  logic out_valid_r, out_valid_nxt;
  pgalloc_pkg::rsp_t out_data_r, out_data_nxt;

  pgalloc_pkg::cell_ctl_t ctl;
  logic [FILL_W-1:0] cell_len;
  logic [pgalloc_pkg::PAGE_W-1:0] cell_q [FREE_DEPTH];
  logic [pgalloc_pkg::PAGE_W-1:0] head;

  logic out_free, accept, last_step, hit_now, kept, go_query, go_search;
  logic [pgalloc_pkg::COUNT_W-1:0] page_ext;

  assign head      = cell_q[0];
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == pgalloc_pkg::ST_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign page_ext  = {1'b0, in_data.page_number};
  assign last_step = (k_r == fill_r - ONE_F);
  assign hit_now   = hit_r || (head == key_r);
  assign kept      = ({1'b0, head} < count_r);
  assign go_query  = (in_data.req_type == pgalloc_pkg::REQ_QUERY) &&
                     (page_ext < count_r) && (fill_r != '0);
  assign go_search = (in_data.req_type == pgalloc_pkg::REQ_COMPACT) &&
                     (count_r != '0) && (fill_r != '0);

  // chain of cells, top of stack at cell 0
  for (genvar i = 0; i < FREE_DEPTH; i++) begin : g_cell
    logic [pgalloc_pkg::PAGE_W-1:0] up_w, dn_w;
    if (i == FREE_DEPTH - 1) begin : g_last
      assign up_w = cell_q[i];
    end else begin : g_mid
      assign up_w = cell_q[i+1];
    end
    if (i == 0) begin : g_first
      assign dn_w = ctl.push_page;
    end else begin : g_rest
      assign dn_w = cell_q[i-1];
    end
    pgalloc_cell #(.IDX(i), .FILL_W(FILL_W)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .len   (cell_len),
      .up_in (up_w),
      .dn_in (dn_w),
      .head  (head),
      .q     (cell_q[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pgalloc_pkg::ST_IDLE: begin
        if (accept && go_query) state_nxt = pgalloc_pkg::ST_QUERY;
        else if (accept && go_search) state_nxt = pgalloc_pkg::ST_SEARCH;
      end
      pgalloc_pkg::ST_QUERY: begin
        if (last_step) state_nxt = pgalloc_pkg::ST_IDLE;
      end
      pgalloc_pkg::ST_SEARCH: begin
        if (last_step && !hit_now) state_nxt = pgalloc_pkg::ST_FILTER;
        else if (last_step && key_r == '0) state_nxt = pgalloc_pkg::ST_IDLE;
      end
      pgalloc_pkg::ST_FILTER: begin
        if (last_step) state_nxt = pgalloc_pkg::ST_IDLE;
      end
      default: state_nxt = pgalloc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pgalloc_pkg::rsp_t res;
    logic load;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    len_nxt       = len_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    ctl.op        = pgalloc_pkg::CELL_HOLD;
    ctl.push_page = in_data.page_number;
    cell_len      = fill_r;
    res           = '0;
    load          = 1'b0;
    unique case (state_r)
      pgalloc_pkg::ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          k_nxt = '0;
          hit_nxt = 1'b0;
          unique case (in_data.req_type)
            pgalloc_pkg::REQ_ALLOC: begin
              if (fill_r != '0) begin
                ctl.op = pgalloc_pkg::CELL_POP;
                res.result_page = head;
                fill_nxt = fill_r - ONE_F;
              end else if (count_r >= PAGE_LIMIT) begin
                res.status = pgalloc_pkg::STS_LIMIT;
              end else begin
                res.result_page = count_r[pgalloc_pkg::PAGE_W-1:0];
                count_nxt = count_r + 1'b1;
              end
            end
            pgalloc_pkg::REQ_FREE: begin
              if (page_ext >= count_r) begin
                res.status = pgalloc_pkg::STS_INVALID;
              end else if (fill_r == DEPTH_F) begin
                res.status = pgalloc_pkg::STS_FULL;
              end else begin
                ctl.op = pgalloc_pkg::CELL_PUSH;
                fill_nxt = fill_r + ONE_F;
              end
            end
            pgalloc_pkg::REQ_QUERY: begin
              key_nxt = in_data.page_number;
              res.page_is_free = (page_ext >= count_r);
              load = !go_query;
            end
            pgalloc_pkg::REQ_WRITE: begin
              if (page_ext >= PAGE_LIMIT) res.status = pgalloc_pkg::STS_LIMIT;
              else if (page_ext >= count_r) count_nxt = page_ext + 1'b1;
            end
            pgalloc_pkg::REQ_COMPACT: begin
              key_nxt = count_r[pgalloc_pkg::PAGE_W-1:0] - 1'b1;
              if (count_r == '0) res.status = pgalloc_pkg::STS_NOCOMPACT;
              load = !go_search;
            end
            pgalloc_pkg::REQ_OPEN: begin
              count_nxt = (init_r > PAGE_LIMIT) ? PAGE_LIMIT : init_r;
              fill_nxt = '0;
            end
            default: res = '0;
          endcase
        end
      end
      pgalloc_pkg::ST_QUERY: begin
        ctl.op = pgalloc_pkg::CELL_ROT;
        hit_nxt = hit_now;
        k_nxt = k_r + ONE_F;
        if (last_step) begin
          res.page_is_free = hit_now;
          load = 1'b1;
        end
      end
      pgalloc_pkg::ST_SEARCH: begin
        ctl.op = pgalloc_pkg::CELL_ROT;
        hit_nxt = hit_now;
        k_nxt = k_r + ONE_F;
        if (last_step) begin
          k_nxt = '0;
          hit_nxt = 1'b0;
          if (!hit_now) begin
            count_nxt = {1'b0, key_r} + 1'b1;
            len_nxt = fill_r;
          end else if (key_r == '0) begin
            res.status = pgalloc_pkg::STS_NOCOMPACT;
            load = 1'b1;
          end else begin
            key_nxt = key_r - 1'b1;
          end
        end
      end
      pgalloc_pkg::ST_FILTER: begin
        ctl.op = kept ? pgalloc_pkg::CELL_ROT : pgalloc_pkg::CELL_DEL;
        cell_len = len_r;
        len_nxt = kept ? len_r : len_r - ONE_F;
        k_nxt = k_r + ONE_F;
        if (last_step) begin
          fill_nxt = len_nxt;
          load = 1'b1;
        end
      end
      default: res = '0;
    endcase

    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pgalloc_pkg::ST_IDLE;
      count_r     <= '0;
      fill_r      <= '0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      len_r       <= '0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      len_r       <= len_nxt;
      hit_r       <= hit_nxt;
      if (cfg_valid && cfg_ready) init_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_F) else $error("free stack fill above depth");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= PAGE_LIMIT) else $error("page count above limit");

  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pgalloc_pkg::ST_IDLE) |-> !out_valid_r)
    else $error("response pending during walk");

  a_filter_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pgalloc_pkg::ST_FILTER) |-> (len_r <= fill_r))
    else $error("filter length above fill");

endmodule

/* rtl/pgalloc_cell.sv */
// One free-stack cell: holds one page number and shifts with its neighbors.
module pgalloc_cell #(
  parameter int IDX    = 0,
  parameter int FILL_W = 7
) (
  input  logic                           clk,
  input  pgalloc_pkg::cell_ctl_t         ctl,
  input  logic [FILL_W-1:0]              len,
  input  logic [pgalloc_pkg::PAGE_W-1:0] up_in,
  input  logic [pgalloc_pkg::PAGE_W-1:0] dn_in,
  input  logic [pgalloc_pkg::PAGE_W-1:0] head,
  output logic [pgalloc_pkg::PAGE_W-1:0] q
);

  localparam logic [FILL_W-1:0] NEXT_IDX = FILL_W'(IDX + 1);

  logic [pgalloc_pkg::PAGE_W-1:0] q_r;
  logic [pgalloc_pkg::PAGE_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    unique case (ctl.op)
      pgalloc_pkg::CELL_HOLD: q_nxt = q_r;
      pgalloc_pkg::CELL_PUSH: q_nxt = dn_in;
      pgalloc_pkg::CELL_POP:  q_nxt = up_in;
      pgalloc_pkg::CELL_ROT: begin
        if (NEXT_IDX < len) q_nxt = up_in;
        else if (NEXT_IDX == len) q_nxt = head;
      end
      pgalloc_pkg::CELL_DEL: begin
        if (NEXT_IDX < len) q_nxt = up_in;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
